// ===== rtl/edf_pkg.sv =====
`timescale 1ns / 1ps
package edf_pkg;
	localparam logic [1:0] CMD_TICK = 2'd0;
	localparam logic [1:0] CMD_DONE = 2'd1;
	localparam logic [1:0] CMD_LOAD = 2'd2;
	localparam logic [0:0] REG_PREEMPT = 1'd0;
	localparam logic [0:0] REG_ACTIVE  = 1'd1;
	localparam logic [31:0] RUN_MAX = 32'hFFFF_FFFF;
	localparam logic [15:0] OVR_MAX = 16'hFFFF;
endpackage

// ===== rtl/edf_ram.sv =====
`timescale 1ns / 1ps
module edf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/periodic_task_edf_scheduler.sv =====
`timescale 1ns / 1ps
// EDF scheduler for up to MAX_TASKS periodic tasks.
// Request channel: command/task_index/task_period/task_wcet/task_deadline with
// in_valid/in_ready. Result channel: running_task, switch_request,
// overrun_flag, ready_mask with out_valid/out_ready, one result per request.
// Configuration: cfg_we/cfg_index/cfg_data, written any cycle, used at once.
// Task records (period, wcet, rel deadline, abs deadline, next release,
// run time, overrun count) sit in one synchronous RAM entry per task; the
// sequencer reads, updates and writes back one entry per step.
// Sequence: load, ignored code and complete with preemption off go straight
// to the output register; complete with preemption on first selects on
// deadlines, reading each entry (S_SEL) and comparing it (S_SELW); tick
// reads and updates each entry (S_RD, S_UPD), then selects likewise when
// preemption is on. The next request can be taken once its result is in
// the output register.
// One request is worked at a time; the next is taken while a result waits in
// the output register, so a stalled receiver only holds the block once a
// second result is ready.
// Reset clears time, current task, ready/stamp/pending flags and the
// configuration (preemption on, no active tasks). RAM contents are not
// cleared; a load writes every field of its entry.
module periodic_task_edf_scheduler
	import edf_pkg::*;
#(
	parameter int MAX_TASKS = 8,
	parameter int TIME_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  command,
	input  logic [3:0]  task_index,
	input  logic [31:0] task_period,
	input  logic [31:0] task_wcet,
	input  logic [31:0] task_deadline,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  running_task,
	output logic        switch_request,
	output logic        overrun_flag,
	output logic [7:0]  ready_mask,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [3:0]  cfg_data
);
	localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int TW = TIME_BITS;
	// entry: period, wcet, rel, abs, next, run, ovr
	localparam int EW = 32 * 3 + TW * 2 + 32 + 16;
	localparam logic [3:0] MT = 4'(MAX_TASKS);

	localparam logic [2:0] S_IDLE = 3'd0, S_RD = 3'd1, S_UPD = 3'd2,
		S_SEL = 3'd3, S_SELW = 3'd4, S_OUT = 3'd5;

	typedef struct packed {
		logic [31:0]   period;
		logic [31:0]   wcet;
		logic [31:0]   rel;
		logic [TW-1:0] abs_dl;
		logic [TW-1:0] next_rel;
		logic [31:0]   run;
		logic [15:0]   ovr;
	} ent_t;

	logic [2:0] st_q;
	logic [TW-1:0] tick_q;
	logic [3:0] cur_q, prev_q, sel_q, n_q;
	logic [TW-1:0] best_q;
	logic [MAX_TASKS-1:0] rdy_q, stamp_q, pend_q;
	logic preempt_q;
	logic [3:0] active_q;
	logic ovr_q;
	logic [AW:0] i_q;
	logic obuf_v_q;
	logic [13:0] obuf_q;

	logic we;
	logic [AW-1:0] waddr, raddr;
	ent_t wd, rd;
	logic [EW-1:0] rd_raw;
	assign rd = ent_t'(rd_raw);

	edf_ram #(.WIDTH(EW), .DEPTH(MAX_TASKS)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(EW'(wd)),
		.raddr(raddr), .rdata(rd_raw));

	wire [3:0] used = (active_q > MT) ? MT : active_q;
	wire [AW-1:0] ia = i_q[AW-1:0];
	wire [3:0] inum = 4'(i_q) + 4'd1;
	wire in_use = inum <= n_q;
	wire is_cur = inum == cur_q;

	assign in_ready = (st_q == S_IDLE);
	assign out_valid = obuf_v_q;
	assign {running_task, switch_request, overrun_flag, ready_mask} = obuf_q;

	logic [7:0] mask8;
	always_comb begin
		mask8 = '0;
		for (int k = 0; k < 8; k++)
			if (k < MAX_TASKS) mask8[k] = rdy_q[k];
	end

	// per-entry tick update
	ent_t up;
	logic do_ovr, nrdy, nstamp, npend;
	always_comb begin
		up = rd;
		nrdy = rdy_q[ia]; nstamp = stamp_q[ia]; npend = pend_q[ia];
		do_ovr = 1'b0;
		if (is_cur && up.run != RUN_MAX) up.run = up.run + 32'd1;
		if (in_use && npend && tick_q >= up.next_rel) begin
			npend = 1'b0; nrdy = 1'b1; up.run = '0;
			up.next_rel = up.next_rel + TW'(up.period);
		end
		if (in_use && nrdy && nstamp) begin
			up.abs_dl = tick_q + TW'(up.rel);
			nstamp = 1'b0;
		end
		if (preempt_q && is_cur && up.run >= up.wcet) begin
			do_ovr = 1'b1; nrdy = 1'b0; nstamp = 1'b1; npend = 1'b1;
			if (up.ovr != OVR_MAX) up.ovr = up.ovr + 16'd1;
		end
	end

	always_comb begin
		we = 1'b0; waddr = ia; raddr = ia; wd = up;
		if (st_q == S_IDLE && in_valid && in_ready && command == CMD_LOAD &&
				task_index != 4'd0 && task_index <= MT) begin
			we = 1'b1;
			waddr = AW'(task_index - 4'd1);
			wd.period = task_period; wd.wcet = task_wcet; wd.rel = task_deadline;
			wd.abs_dl = '0; wd.next_rel = TW'(task_period); wd.run = '0; wd.ovr = '0;
		end else if (st_q == S_UPD) begin
			we = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE; tick_q <= '0; cur_q <= '0; prev_q <= '0;
			rdy_q <= '0; stamp_q <= '0; pend_q <= '0;
			preempt_q <= 1'b1; active_q <= '0; obuf_v_q <= 1'b0;
			i_q <= '0; ovr_q <= 1'b0; sel_q <= '0; n_q <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_PREEMPT) preempt_q <= cfg_data[0];
				else active_q <= cfg_data;
			end
			// in S_OUT the register is refilled instead
			if (obuf_v_q && out_ready && st_q != S_OUT) obuf_v_q <= 1'b0;
			case (st_q)
				S_IDLE: if (in_valid && in_ready) begin
					prev_q <= cur_q; ovr_q <= 1'b0; n_q <= used; i_q <= '0;
					if (command == CMD_TICK) begin
						tick_q <= tick_q + TW'(1);
						st_q <= S_RD;
					end else if (command == CMD_DONE) begin
						if (task_index != 4'd0 && task_index <= MT) begin
							rdy_q[AW'(task_index - 4'd1)] <= 1'b0;
							stamp_q[AW'(task_index - 4'd1)] <= 1'b1;
							pend_q[AW'(task_index - 4'd1)] <= 1'b1;
						end
						st_q <= preempt_q ? S_SEL : S_OUT;
					end else begin
						if (command == CMD_LOAD && task_index != 4'd0 && task_index <= MT) begin
							rdy_q[AW'(task_index - 4'd1)] <= 1'b1;
							stamp_q[AW'(task_index - 4'd1)] <= 1'b1;
							pend_q[AW'(task_index - 4'd1)] <= 1'b0;
						end
						st_q <= S_OUT;
					end
				end
				S_RD: st_q <= S_UPD;
				S_UPD: begin
					rdy_q[ia] <= nrdy; stamp_q[ia] <= nstamp; pend_q[ia] <= npend;
					if (do_ovr) ovr_q <= 1'b1;
					if (i_q == (AW+1)'(MAX_TASKS - 1)) begin
						i_q <= '0;
						st_q <= preempt_q ? S_SEL : S_OUT;
					end else begin
						i_q <= i_q + 1'b1;
						st_q <= S_RD;
					end
				end
				S_SEL: begin
					// issue read for entry i; compare in S_SELW
					sel_q <= (i_q == '0) ? 4'd0 : sel_q;
					st_q <= S_SELW;
				end
				S_SELW: begin
					if (in_use && rdy_q[ia] && (sel_q == 4'd0 || rd.abs_dl < best_q)) begin
						sel_q <= inum; best_q <= rd.abs_dl;
					end
					if (i_q == (AW+1)'(MAX_TASKS - 1)) begin
						st_q <= S_OUT;
						if (in_use && rdy_q[ia] && (sel_q == 4'd0 || rd.abs_dl < best_q))
							cur_q <= inum;
						else cur_q <= sel_q;
					end else begin
						i_q <= i_q + 1'b1;
						st_q <= S_SEL;
					end
				end
				// wait here while the previous result is still held
				S_OUT: if (!obuf_v_q || out_ready) begin
					obuf_v_q <= 1'b1;
					obuf_q <= {cur_q, cur_q != prev_q, ovr_q, mask8};
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule
